// ===== hdl/uwbimu_pkg.sv =====
// Package for the UWB/IMU serial frame parser: frame codes, lengths and the
// sequencer state type. No dependencies.
package uwbimu_pkg;

    localparam logic [7:0] TYPE_RANGE = 8'h0C;
    localparam logic [7:0] TYPE_IMU   = 8'h0B;

    // Frame lengths in bytes, including header, type and checksum
    localparam logic [4:0] LEN_RANGE = 5'd15;
    localparam logic [4:0] LEN_IMU   = 5'd29;

    // First payload byte position (after header, type and timestamp)
    localparam logic [4:0] POS_DATA  = 5'd6;
    localparam logic [4:0] POS_TS_LO = 5'd2;
    localparam logic [4:0] POS_TS_HI = 5'd5;

    // Index of the final result of each frame kind
    localparam logic [3:0] LAST_RANGE = 4'd3;
    localparam logic [3:0] LAST_IMU   = 4'd10;
    localparam int         NUM_WORDS  = 11;

    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_IMU   = 1'b1;

    // Register indexes on the configuration port
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    localparam logic [7:0]  HEADER_RESET = 8'h0A;
    localparam logic [15:0] OFFSET_RESET = 16'd400;

    typedef enum logic [1:0] {
        ST_HUNT = 2'd0,
        ST_TYPE = 2'd1,
        ST_BODY = 2'd2,
        ST_EMIT = 2'd3
    } parse_state_t;

endpackage

// ===== hdl/uwb_imu_frame_parser_core.sv =====
// UWB/IMU serial frame parser, top level.
// Depends on uwbimu_pkg (frame codes, lengths, state type).
//
//  Channel   Handshake            Payload
//  -------   ------------------   --------------------------------------------
//  input     in_valid / in_stall  rx_byte[7:0]
//  output    out_valid/out_stall  frame_kind, timestamp_ms[31:0],
//                                 value_index[3:0], value[16:0] signed, last
//  config    APB (psel..pready)   reg 0 header_byte @0x0, reg 1 range_offset_mm @0x4
//
// Flow: received bytes are taken while the input is not stalled. After a good checksum
// the block stalls its input while one shared convert unit (offset subtract and clamp,
// or sign extension) produces one result per cycle from the stored words, unless the
// output stalls: 4 results for a range frame, 11 for an IMU frame.
// Reset: asynchronous, active low; clears the sequencer, the checksum and the
// output valid. Stored frame words need no reset: each is written before use.
// Stalls: the output beat sits in a register, so the last result of a frame
// may wait while the next frame's bytes are already being taken.
module uwb_imu_frame_parser_core (
    input  logic                    clk,
    input  logic                    rst_n,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              rx_byte,
    // output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    frame_kind,
    output logic [31:0]             timestamp_ms,
    output logic [3:0]              value_index,
    output logic signed [16:0]      value,
    output logic                    last,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import uwbimu_pkg::*;

    // Configuration registers
    logic [7:0]   header_reg;
    logic [15:0]  offset_reg;

    // Sequencer and frame bookkeeping
    parse_state_t state_reg, state_next;
    logic         ftype_reg;
    logic [4:0]   count_reg;
    logic [7:0]   sum_reg;
    logic [3:0]   emit_idx_reg;

    // Frame payload: timestamp and 16-bit words, assembled as bytes arrive
    logic [31:0]  ts_reg;
    logic [7:0]   hi_reg;
    logic [15:0]  word_mem [NUM_WORDS];

    // Output register
    logic               out_valid_reg;
    logic               kind_out_reg;
    logic [31:0]        ts_out_reg;
    logic [3:0]         idx_out_reg;
    logic signed [16:0] value_out_reg;
    logic               last_out_reg;

    logic         in_acc;
    logic         emit_load;
    logic [4:0]   frame_len;
    logic [7:0]   sum_next;
    logic         type_ok;
    logic         at_check;
    logic         body_store;
    logic [4:0]   data_off;
    logic [3:0]   word_idx;
    logic [15:0]  raw_word;
    logic [16:0]  diff;
    logic signed [16:0] conv_value;
    logic         emit_last;
    logic         cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port: writes land on the access cycle, reads are plain
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_HEADER: header_reg <= pwdata[7:0];
                REG_OFFSET: offset_reg <= pwdata[15:0];
                default:    header_reg <= header_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_HEADER: prdata = {24'd0, header_reg};
            REG_OFFSET: prdata = {16'd0, offset_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Byte-level decode
    // ------------------------------------------------------------------
    assign in_acc     = in_valid & ~in_stall;
    assign frame_len  = ftype_reg ? LEN_IMU : LEN_RANGE;
    assign sum_next   = sum_reg + rx_byte;
    assign type_ok    = (rx_byte == TYPE_RANGE) || (rx_byte == TYPE_IMU);
    assign at_check   = (count_reg == frame_len - 5'd1);
    assign body_store = (count_reg < frame_len - 5'd1);
    assign data_off   = count_reg - POS_DATA;
    assign word_idx   = data_off[4:1];

    // ------------------------------------------------------------------
    // Shared convert unit, if not stalled: one stored word per cycle into one result
    // ------------------------------------------------------------------
    assign raw_word  = word_mem[emit_idx_reg];
    assign diff      = {1'b0, raw_word} - {1'b0, offset_reg};
    assign emit_last = ftype_reg ? (emit_idx_reg == LAST_IMU)
                                 : (emit_idx_reg == LAST_RANGE);

    always_comb
    begin
        if (ftype_reg == KIND_IMU)
            conv_value = {raw_word[15], raw_word};
        else if (diff[16])
            conv_value = 17'sd0;   // raw below offset: clamp at zero
        else
            conv_value = diff;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (in_acc && rx_byte == header_reg)
                    state_next = ST_TYPE;
            end
            ST_TYPE:
            begin
                if (in_acc)
                    state_next = type_ok ? ST_BODY : ST_HUNT;
            end
            ST_BODY:
            begin
                if (in_acc)
                begin
                    priority if (!body_store && !at_check)
                        state_next = ST_HUNT;
                    else if (at_check)
                        state_next = (rx_byte == sum_reg) ? ST_EMIT : ST_HUNT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load && emit_last)
                    state_next = ST_HUNT;
            end
            default: state_next = ST_HUNT;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = (state_reg == ST_EMIT);
        emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_HUNT;
            ftype_reg    <= KIND_RANGE;
            count_reg    <= 5'd0;
            sum_reg      <= 8'd0;
            emit_idx_reg <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                unique case (state_reg)
                    ST_TYPE:
                    begin
                        if (type_ok)
                        begin
                            sum_reg   <= sum_next;
                            ftype_reg <= (rx_byte == TYPE_IMU);
                            count_reg <= 5'd2;
                        end
                        else
                            count_reg <= 5'd0;
                    end
                    ST_BODY:
                    begin
                        if (body_store)
                        begin
                            sum_reg   <= sum_next;
                            count_reg <= count_reg + 5'd1;
                        end
                        else
                            count_reg <= 5'd0;
                        emit_idx_reg <= 4'd0;
                    end
                    default:
                    begin
                        // hunting, including any unused code
                        if (rx_byte == header_reg)
                        begin
                            sum_reg   <= rx_byte;
                            count_reg <= 5'd1;
                        end
                    end
                endcase
            end
            if (emit_load)
                emit_idx_reg <= emit_idx_reg + 4'd1;
        end
    end

    // Frame payload capture
    always_ff @(posedge clk)
    begin
        if (in_acc && state_reg == ST_BODY && body_store)
        begin
            if (count_reg >= POS_TS_LO && count_reg <= POS_TS_HI)
                ts_reg <= {ts_reg[23:0], rx_byte};
            if (count_reg >= POS_DATA)
            begin
                if (!data_off[0])
                    hi_reg <= rx_byte;
                else
                    word_mem[word_idx] <= {hi_reg, rx_byte};
            end
        end
    end

    // Output register: advance when empty or taken, drop valid when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            kind_out_reg  <= ftype_reg;
            ts_out_reg    <= ts_reg;
            idx_out_reg   <= emit_idx_reg;
            value_out_reg <= conv_value;
            last_out_reg  <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_kind   = kind_out_reg;
    assign timestamp_ms = ts_out_reg;
    assign value_index  = idx_out_reg;
    assign value        = value_out_reg;
    assign last         = last_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BODY) |-> (count_reg >= 5'd2 && count_reg < frame_len))
        else $error("byte count out of frame bounds");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_out_reg) |->
            ((kind_out_reg && idx_out_reg == LAST_IMU) ||
             (!kind_out_reg && idx_out_reg == LAST_RANGE)))
        else $error("last flag on wrong result index");

    a_range_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !kind_out_reg) |-> !value_out_reg[16])
        else $error("range result below zero");

    a_emit_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BODY && state_next == ST_EMIT) |=> (emit_idx_reg == 4'd0))
        else $error("result sequence not restarted");

endmodule

// ===== tb/sv/uwb_imu_frame_parser_core_tb.sv =====
// Self-checking testbench for uwb_imu_frame_parser_core: byte stimulus, APB set-up,
// a cycle-accurate-in-content predictor and a result scoreboard.
// Depends on uwbimu_pkg and the parser RTL only.
`timescale 1ns / 1ps

module uwb_imu_frame_parser_core_tb;

    import uwbimu_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    // Longest quiet stretch the block may need after its last result, with margin
    localparam int DRAIN_CYCLES = 24;
    localparam logic [2:0] ADDR_HEADER = {REG_HEADER, 2'b00};
    localparam logic [2:0] ADDR_OFFSET = {REG_OFFSET, 2'b00};

    typedef struct packed {
        logic               kind;
        logic [31:0]        ts;
        logic [3:0]         idx;
        logic signed [16:0] val;
        logic               last;
    } parser_result_t;

    // DUT inputs, all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'h0;

    // DUT outputs
    logic               in_stall;
    logic               out_valid;
    logic               frame_kind;
    logic [31:0]        timestamp_ms;
    logic [3:0]         value_index;
    logic signed [16:0] value;
    logic               last;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state and its copy of the registers
    parse_state_t pr_state  = ST_HUNT;
    logic         pr_imu    = 1'b0;
    logic [4:0]   pr_count  = 5'd0;
    logic [7:0]   pr_sum    = 8'h00;
    logic [7:0]   pr_bytes [29];
    logic [7:0]   cfg_header = HEADER_RESET;
    logic [15:0]  cfg_offset = OFFSET_RESET;

    parser_result_t expected_results [$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int fail_count    = 0;
    int total_bytes   = 0;
    int frames_sent   = 0;
    int results_seen  = 0;
    int settings_used = 0;

    uwb_imu_frame_parser_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_kind   (frame_kind),
        .timestamp_ms (timestamp_ms),
        .value_index  (value_index),
        .value        (value),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 clk = ~clk;

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stall, or a long counted hold-off when one is requested.
    // The request is sampled at an edge after the test raises it, so no race.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_request > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_request - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Scoreboard: compare every accepted output beat with the oldest expectation
    always @(posedge clk)
    begin
        parser_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: kind %0d index %0d value %0h",
                       frame_kind, value_index, value);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("frame_kind", want.kind, frame_kind);
                check_field("timestamp_ms", want.ts, timestamp_ms);
                check_field("value_index", want.idx, value_index);
                check_field("value", want.val, value);
                check_field("last", want.last, last);
                results_seen++;
            end
        end
    end

    // Advance the frame predictor by one accepted byte; queue any results it yields
    task automatic predict_byte(input logic [7:0] b);
        logic [4:0]     len;
        logic [31:0]    ts;
        logic [15:0]    raw;
        parser_result_t r;
        int             n;
        case (pr_state)
            ST_TYPE:
            begin
                if (b == TYPE_RANGE || b == TYPE_IMU)
                begin
                    pr_bytes[1] = b;
                    pr_sum      = pr_sum + b;
                    pr_imu      = (b == TYPE_IMU);
                    pr_count    = 5'd2;
                    pr_state    = ST_BODY;
                end
                else
                begin
                    // drop header and type; the type byte is not a new header
                    pr_state = ST_HUNT;
                    pr_count = 5'd0;
                end
            end
            ST_BODY:
            begin
                len = pr_imu ? LEN_IMU : LEN_RANGE;
                if (pr_count < len - 5'd1)
                begin
                    pr_bytes[pr_count] = b;
                    pr_sum             = pr_sum + b;
                    pr_count           = pr_count + 5'd1;
                end
                else
                begin
                    pr_state = ST_HUNT;
                    pr_count = 5'd0;
                    if (b == pr_sum)
                    begin
                        ts = {pr_bytes[2], pr_bytes[3], pr_bytes[4], pr_bytes[5]};
                        n  = pr_imu ? NUM_WORDS : int'(LAST_RANGE) + 1;
                        for (int k = 0; k < n; k++)
                        begin
                            raw    = {pr_bytes[int'(POS_DATA) + 2 * k],
                                      pr_bytes[int'(POS_DATA) + 2 * k + 1]};
                            r.kind = pr_imu ? KIND_IMU : KIND_RANGE;
                            r.ts   = ts;
                            r.idx  = 4'(k);
                            if (pr_imu)
                                r.val = {raw[15], raw};
                            else if (raw > cfg_offset)
                                r.val = {1'b0, raw - cfg_offset};
                            else
                                r.val = '0;
                            r.last = (k == n - 1);
                            expected_results.push_back(r);
                        end
                    end
                end
            end
            default:
            begin
                pr_state = ST_HUNT;
                if (b == cfg_header)
                begin
                    pr_bytes[0] = b;
                    pr_sum      = b;
                    pr_count    = 5'd1;
                    pr_state    = ST_TYPE;
                end
            end
        endcase
    endtask

    // Offer one byte, with random idle cycles first; valid stays high into the
    // next beat unless a gap is drawn
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b);
        total_bytes++;
    endtask

    // Build and send a complete frame under the current header; optionally spoil the checksum
    task automatic send_frame(input bit imu, input logic [31:0] ts,
                              input logic [15:0] w [11], input bit bad_sum);
        logic [7:0] fb [$];
        logic [7:0] sum;
        int         n;
        n = imu ? NUM_WORDS : int'(LAST_RANGE) + 1;
        fb.push_back(cfg_header);
        fb.push_back(imu ? TYPE_IMU : TYPE_RANGE);
        for (int i = 0; i < 4; i++)
            fb.push_back(ts[31 - 8 * i -: 8]);
        for (int k = 0; k < n; k++)
        begin
            fb.push_back(w[k][15:8]);
            fb.push_back(w[k][7:0]);
        end
        sum = 8'h00;
        foreach (fb[i])
            sum = sum + fb[i];
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(255, 1));
        fb.push_back(sum);
        foreach (fb[i])
            send_byte(fb[i]);
        frames_sent++;
    endtask

    task automatic send_random_frame(input bit bad_sum);
        logic [15:0] w [11];
        logic [15:0] corner [4];
        bit          imu;
        corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        imu    = $urandom_range(1, 0);
        for (int k = 0; k < 11; k++)
        begin
            case ($urandom_range(3))
                0:       w[k] = cfg_offset + 16'($urandom_range(2)) - 16'd1;
                1:       w[k] = corner[$urandom_range(3)];
                default: w[k] = 16'($urandom);
            endcase
        end
        send_frame(imu, $urandom, w, bad_sum);
    endtask

    // Hold the input low until every expected result is out and the block has gone quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup then access; back-to-back transfers keep psel high
    task automatic apb_access(input bit wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
    endtask

    task automatic set_config(input logic [7:0] hdr, input logic [15:0] off);
        logic [31:0] rd;
        wait_idle();
        apb_access(1'b1, ADDR_HEADER, {24'h0, hdr}, rd);
        apb_access(1'b1, ADDR_OFFSET, {16'h0, off}, rd);
        cfg_header = hdr;
        cfg_offset = off;
        apb_access(1'b0, ADDR_HEADER, 32'h0, rd);
        check_field("header_byte readback", {24'h0, hdr}, rd);
        apb_access(1'b0, ADDR_OFFSET, 32'h0, rd);
        check_field("range_offset_mm readback", {16'h0, off}, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // Mixed traffic: mostly good frames, the rest spoilt, unknown, noise or cut short
    task automatic run_traffic(input int idle, input int stall, input int nbytes);
        int         start;
        int         pick;
        logic [7:0] t;
        idle_pct  = idle;
        stall_pct <= stall;
        start     = total_bytes;
        while (total_bytes - start < nbytes)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_random_frame(1'b0);
            else if (pick < 78)
                send_random_frame(1'b1);
            else if (pick < 86)
            begin
                do
                    t = 8'($urandom);
                while (t == TYPE_RANGE || t == TYPE_IMU);
                send_byte(cfg_header);
                send_byte(t);
            end
            else if (pick < 94)
            begin
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
            end
            else
            begin
                // truncated frame: the following bytes get swallowed as its body
                send_byte(cfg_header);
                send_byte($urandom_range(1, 0) ? TYPE_IMU : TYPE_RANGE);
                repeat ($urandom_range(8)) send_byte(8'($urandom));
            end
        end
    endtask

    // Reset register values, ignored noise, unknown types and frame corner values
    task automatic test_directed_cases();
        logic [15:0] w [11];
        idle_pct  = 0;
        stall_pct <= 0;
        send_byte(8'h55);
        send_byte(8'hFF);
        // header then header again: the second one is an unknown type, not a restart
        send_byte(HEADER_RESET);
        send_byte(HEADER_RESET);
        send_byte(HEADER_RESET);
        send_byte(8'h00);
        w = '{default: 16'h0000};
        w[0] = 16'd0;
        w[1] = OFFSET_RESET;
        w[2] = OFFSET_RESET + 16'd1;
        w[3] = 16'hFFFF;
        send_frame(1'b0, 32'hFFFF_FFFF, w, 1'b0);
        w = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001, 16'hFF00,
              16'h00FF, 16'hA5A5, 16'h5A5A, 16'h1234, 16'hFEDC};
        send_frame(1'b1, 32'h0000_0000, w, 1'b0);
    endtask

    // Register extremes, each followed by traffic that exercises it
    task automatic test_register_extremes();
        logic [15:0] w [11];
        set_config(8'h00, 16'd0);
        w = '{default: 16'hFFFF};
        send_frame(1'b0, 32'h8000_0001, w, 1'b0);
        run_traffic(0, 0, 50);
        set_config(8'hFF, 16'hFFFF);
        send_frame(1'b0, 32'h0000_8000, w, 1'b0);
        run_traffic(20, 20, 50);
    endtask

    // Random settings under each idle and stall mix
    task automatic test_random_traffic();
        int idle_mix [4];
        int stall_mix [4];
        idle_mix  = '{0, 85, 0, 32};
        stall_mix = '{0, 0, 85, 32};
        for (int p = 0; p < 4; p++)
        begin
            set_config(8'($urandom), 16'($urandom_range(3000)));
            run_traffic(idle_mix[p], stall_mix[p], 50);
        end
    endtask

    // Hold the output off for a long stretch while frames keep coming, so the
    // block fills and stalls its input
    task automatic test_backpressure();
        idle_pct     = 0;
        stall_pct    <= 0;
        in_valid     <= 1'b0;
        hold_request <= 300;
        @(posedge clk);
        hold_request <= 0;
        repeat (3) send_random_frame(1'b0);
    endtask

    initial
    begin
        foreach (pr_bytes[i])
            pr_bytes[i] = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        $display("Sent %0d bytes in %0d frames, checked %0d results", total_bytes,
                 frames_sent, results_seen);
        $display("across %0d register settings, four idle/stall mixes and a long hold-off",
                 settings_used + 1);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/uwbimu_pkg.sv
hdl/uwb_imu_frame_parser_core.sv
tb/sv/uwb_imu_frame_parser_core_tb.sv
